// ----- rtl/pelf_pkg.sv -----
// Shared types and constants of the PCR event log filter.
`default_nettype none
package pelf_pkg;

    localparam int unsigned MAX_NAME_BYTES_DEF = 255;
    localparam int unsigned DIGEST_BYTES_DEF   = 20;

    localparam logic [31:0] TARGET_PCR_RST  = 32'd10;
    localparam logic [15:0] FIRST_ENTRY_RST = 16'd0;
    localparam logic [15:0] MAX_EVENTS_RST  = 16'd1;
    localparam logic [1:0]  MODE_RST        = 2'd0;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned NAME_LIMIT  = 41;
    localparam logic [7:0]  NUL_BYTE    = 8'h00;

    localparam int unsigned PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TARGET_PCR  = 2'd0,
        REG_FIRST_ENTRY = 2'd1,
        REG_MAX_EVENTS  = 2'd2,
        REG_MODE        = 2'd3
    } reg_idx_t;

    localparam logic [1:0] MODE_RANGE  = 2'd0;
    localparam logic [1:0] MODE_SINGLE = 2'd1;

    localparam logic [1:0] KIND_DIGEST  = 2'd0;
    localparam logic [1:0] KIND_TYPE    = 2'd1;
    localparam logic [1:0] KIND_NAME    = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NAME_LONG = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam logic REQ_END = 1'b1;

    typedef struct packed {
        logic [31:0] target_pcr;
        logic [15:0] first_entry;
        logic [15:0] max_events;
        logic [1:0]  mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic [15:0] record_number;
        logic        record_end;
        logic [15:0] copied_count;
        logic [15:0] match_count;
        logic [1:0]  status;
        logic        last_item;
    } res_t;

endpackage
`default_nettype wire

// ----- rtl/pelf_apb_regs.sv -----
// APB configuration registers of the PCR event log filter.
`default_nettype none
module pelf_apb_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pelf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output pelf_pkg::cfg_t                    cfg
);

    pelf_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_pcr  <= pelf_pkg::TARGET_PCR_RST;
            cfg_reg.first_entry <= pelf_pkg::FIRST_ENTRY_RST;
            cfg_reg.max_events  <= pelf_pkg::MAX_EVENTS_RST;
            cfg_reg.mode        <= pelf_pkg::MODE_RST;
        end else if (wr_en) begin
            unique case (pelf_pkg::reg_idx_t'(idx))
                pelf_pkg::REG_TARGET_PCR:  cfg_reg.target_pcr  <= pwdata;
                pelf_pkg::REG_FIRST_ENTRY: cfg_reg.first_entry <= pwdata[15:0];
                pelf_pkg::REG_MAX_EVENTS:  cfg_reg.max_events  <= pwdata[15:0];
                pelf_pkg::REG_MODE:        cfg_reg.mode        <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (pelf_pkg::reg_idx_t'(idx))
            pelf_pkg::REG_TARGET_PCR:  prdata = cfg_reg.target_pcr;
            pelf_pkg::REG_FIRST_ENTRY: prdata = {16'd0, cfg_reg.first_entry};
            pelf_pkg::REG_MAX_EVENTS:  prdata = {16'd0, cfg_reg.max_events};
            pelf_pkg::REG_MODE:        prdata = {30'd0, cfg_reg.mode};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/pelf_front.sv -----
// Front end: accepts log bytes, tracks record fields and classifies matches.
`default_nettype none
module pelf_front #(
    parameter int unsigned MAX_NAME_BYTES = pelf_pkg::MAX_NAME_BYTES_DEF,
    parameter int unsigned DIGEST_BYTES   = pelf_pkg::DIGEST_BYTES_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire pelf_pkg::cfg_t cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           req_type,
    input  wire logic [7:0]     log_byte,
    input  wire logic           q_full,
    output logic                push,
    output pelf_pkg::res_t      push_data
);

    typedef enum logic [1:0] {
        PH_INDEX,
        PH_DIGEST,
        PH_TYPE,
        PH_NAME
    } phase_t;

    localparam logic [7:0] DIGEST_LAST = 8'(DIGEST_BYTES - 1);
    localparam logic [7:0] NAME_MAX    = 8'(MAX_NAME_BYTES);
    localparam logic [7:0] NAME_LIM    = 8'(pelf_pkg::NAME_LIMIT);

    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [23:0] index_reg, index_next;
    logic [15:0] matches_reg, matches_next;
    logic [15:0] copied_reg, copied_next;
    logic        sel_reg, sel_next;
    logic        done_reg, done_next;
    logic        name_long_reg, name_long_next;

    logic        accept;
    logic [31:0] index_word;
    logic        hit;
    logic        pick;
    logic [1:0]  sum_status;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign index_word = {log_byte, index_reg};
    assign hit        = (index_word == cfg.target_pcr);

    always_comb begin
        unique case (cfg.mode)
            pelf_pkg::MODE_RANGE:
                pick = (matches_reg >= cfg.first_entry) && (copied_reg < cfg.max_events);
            pelf_pkg::MODE_SINGLE:
                pick = !done_reg && (matches_reg == cfg.first_entry);
            default:
                pick = 1'b0;
        endcase
    end

    always_comb begin
        priority if (name_long_reg) begin
            sum_status = pelf_pkg::ST_NAME_LONG;
        end else if (phase_reg != PH_INDEX || pos_reg != 8'd0) begin
            sum_status = pelf_pkg::ST_TRUNCATED;
        end else if (cfg.mode == pelf_pkg::MODE_SINGLE && !done_reg) begin
            sum_status = pelf_pkg::ST_NOT_FOUND;
        end else begin
            sum_status = pelf_pkg::ST_OK;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        index_next     = index_reg;
        matches_next   = matches_reg;
        copied_next    = copied_reg;
        sel_next       = sel_reg;
        done_next      = done_reg;
        name_long_next = name_long_reg;
        push           = 1'b0;

        push_data.out_kind      = pelf_pkg::KIND_NAME;
        push_data.out_byte      = log_byte;
        push_data.record_number = copied_reg;
        push_data.record_end    = 1'b0;
        push_data.copied_count  = copied_reg;
        push_data.match_count   = matches_reg;
        push_data.status        = pelf_pkg::ST_OK;
        push_data.last_item     = 1'b0;

        if (accept) begin
            if (req_type == pelf_pkg::REQ_END) begin
                push                 = 1'b1;
                push_data.out_kind   = pelf_pkg::KIND_SUMMARY;
                push_data.out_byte   = 8'd0;
                push_data.status     = sum_status;
                push_data.last_item  = 1'b1;
                phase_next     = PH_INDEX;
                pos_next       = 8'd0;
                index_next     = 24'd0;
                matches_next   = 16'd0;
                copied_next    = 16'd0;
                sel_next       = 1'b0;
                done_next      = 1'b0;
                name_long_next = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_INDEX: begin
                        unique case (pos_reg[1:0])
                            2'd0: index_next = {16'd0, log_byte};
                            2'd1: index_next = {8'd0, log_byte, index_reg[7:0]};
                            2'd2: index_next = {log_byte, index_reg[15:0]};
                            default: index_next = index_reg;
                        endcase
                        pos_next = pos_reg + 8'd1;
                        if (pos_reg[1:0] == 2'd3) begin
                            sel_next = hit && pick;
                            if (hit) begin
                                matches_next = sat_inc(matches_reg);
                                if (cfg.mode == pelf_pkg::MODE_SINGLE && pick) begin
                                    done_next = 1'b1;
                                end
                            end
                            index_next = 24'd0;
                            pos_next   = 8'd0;
                            phase_next = PH_DIGEST;
                        end
                    end
                    PH_DIGEST: begin
                        pos_next = pos_reg + 8'd1;
                        if (pos_reg >= DIGEST_LAST) begin
                            pos_next   = 8'd0;
                            phase_next = PH_TYPE;
                        end
                        push               = sel_reg;
                        push_data.out_kind = pelf_pkg::KIND_DIGEST;
                    end
                    PH_TYPE: begin
                        pos_next = pos_reg + 8'd1;
                        if (pos_reg >= 8'd3) begin
                            pos_next   = 8'd0;
                            phase_next = PH_NAME;
                        end
                        push               = sel_reg;
                        push_data.out_kind = pelf_pkg::KIND_TYPE;
                    end
                    PH_NAME: begin
                        if (log_byte != pelf_pkg::NUL_BYTE) begin
                            if (pos_reg != 8'hFF) begin
                                pos_next = pos_reg + 8'd1;
                            end
                            push = sel_reg && (pos_reg < NAME_MAX);
                        end else begin
                            if (sel_reg && cfg.mode == pelf_pkg::MODE_SINGLE
                                && pos_reg >= NAME_LIM) begin
                                name_long_next = 1'b1;
                            end
                            pos_next   = 8'd0;
                            phase_next = PH_INDEX;
                            sel_next   = 1'b0;
                            if (sel_reg) begin
                                copied_next            = sat_inc(copied_reg);
                                push                   = 1'b1;
                                push_data.record_end   = 1'b1;
                                push_data.copied_count = sat_inc(copied_reg);
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_INDEX;
            pos_reg       <= 8'd0;
            index_reg     <= 24'd0;
            matches_reg   <= 16'd0;
            copied_reg    <= 16'd0;
            sel_reg       <= 1'b0;
            done_reg      <= 1'b0;
            name_long_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            index_reg     <= index_next;
            matches_reg   <= matches_next;
            copied_reg    <= copied_next;
            sel_reg       <= sel_next;
            done_reg      <= done_next;
            name_long_reg <= name_long_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pelf_queue.sv -----
// Short result queue between the front end and the output stage.
`default_nettype none
module pelf_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire pelf_pkg::res_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                q_valid,
    output pelf_pkg::res_t      pop_data
);

    localparam int unsigned PTR_W = $clog2(pelf_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(pelf_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(pelf_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(pelf_pkg::QUEUE_DEPTH - 1);

    pelf_pkg::res_t   mem_reg [pelf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == DEPTH_CNT);
    assign q_valid  = (count_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && q_valid;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pelf_back.sv -----
// Back end: output register that presents queued results on the result channel.
`default_nettype none
module pelf_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire pelf_pkg::res_t q_data,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output pelf_pkg::res_t      out_data
);

    logic           valid_reg, valid_next;
    pelf_pkg::res_t data_reg;

    assign pop        = q_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= q_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/pcr_event_log_filter.sv -----
// Top level of the PCR event log filter.
//
//  channel  direction  transaction
//  s_       in         one log byte or an end-of-log marker
//  m_       out        one copied record byte or the closing summary
//  apb      in         register write or read, always ready
//
//  One log byte is taken per cycle while s_ready is high; the front end decides it in that cycle.
//  A result passes through the queue and then the output register before it leaves.
//  s_ready falls only when the four-entry result queue is full.
//  Reset: aresetn synchronous, active low; resets parser, queue and registers.
//  An end-of-log summary returns the parser to its reset state; registers keep.
`default_nettype none
module pcr_event_log_filter #(
    parameter int unsigned MAX_NAME_BYTES = pelf_pkg::MAX_NAME_BYTES_DEF,
    parameter int unsigned DIGEST_BYTES   = pelf_pkg::DIGEST_BYTES_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pelf_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_req_type,
    input  wire logic [7:0]                   s_log_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [1:0]                   m_out_kind,
    output logic      [7:0]                   m_out_byte,
    output logic      [15:0]                  m_record_number,
    output logic                              m_record_end,
    output logic      [15:0]                  m_copied_count,
    output logic      [15:0]                  m_match_count,
    output logic      [1:0]                   m_status,
    output logic                              m_last_item
);

    pelf_pkg::cfg_t cfg;
    pelf_pkg::res_t push_data;
    pelf_pkg::res_t q_data;
    pelf_pkg::res_t out_data;
    logic           push;
    logic           q_full;
    logic           q_valid;
    logic           pop;

    pelf_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pelf_front #(
        .MAX_NAME_BYTES (MAX_NAME_BYTES),
        .DIGEST_BYTES   (DIGEST_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .req_type  (s_req_type),
        .log_byte  (s_log_byte),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    pelf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_data  (q_data)
    );

    pelf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_out_kind      = out_data.out_kind;
    assign m_out_byte      = out_data.out_byte;
    assign m_record_number = out_data.record_number;
    assign m_record_end    = out_data.record_end;
    assign m_copied_count  = out_data.copied_count;
    assign m_match_count   = out_data.match_count;
    assign m_status        = out_data.status;
    assign m_last_item     = out_data.last_item;

endmodule
`default_nettype wire
